// ===== design/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and codes for the MOVEM register list sequencer.
// ----------------------------------------------------------------------------
package mvm_pkg;

    // Operation codes of an instruction.
    localparam logic [1:0] OP_STORE_CTRL   = 2'd0;
    localparam logic [1:0] OP_STORE_PREDEC = 2'd1;
    localparam logic [1:0] OP_LOAD_CTRL    = 2'd2;
    localparam logic [1:0] OP_LOAD_POSTINC = 2'd3;

    // How a loaded value fills its register.
    localparam logic [1:0] KIND_LONG      = 2'd0;
    localparam logic [1:0] KIND_LOW_WORD  = 2'd1;
    localparam logic [1:0] KIND_SIGN_WORD = 2'd2;

    // Operand sizes in bytes.
    localparam logic [31:0] SIZE_WORD = 32'd2;
    localparam logic [31:0] SIZE_LONG = 32'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
    } status_t;

endpackage

// ===== design/mvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mvm_ctrl
// Controller: takes an instruction and steps the datapath once per result.
// ----------------------------------------------------------------------------
module mvm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mvm_pkg::status_t status,
    output mvm_pkg::cmd_t    cmd,
    output logic             busy
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ST_RUN);

endmodule

// ===== design/mvm_datapath.sv =====
// ----------------------------------------------------------------------------
// mvm_datapath
// Datapath: remaining mask, running address and the registered result.
// ----------------------------------------------------------------------------
module mvm_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  mvm_pkg::cmd_t    cmd,
    output mvm_pkg::status_t status,
    input  logic [1:0]       opcode,
    input  logic             long_size,
    input  logic [15:0]      reg_mask,
    input  logic [31:0]      start_address,
    input  logic [2:0]       base_reg,
    output logic             result_valid,
    output logic             transfer_valid,
    output logic [3:0]       reg_index,
    output logic [31:0]      mem_address,
    output logic             is_write,
    output logic [1:0]       load_kind,
    output logic             last,
    output logic             writeback_valid,
    output logic [2:0]       writeback_reg,
    output logic [31:0]      writeback_value
);

    logic [15:0] mask_reg;
    logic [31:0] addr_reg;
    logic [1:0]  op_reg;
    logic        long_reg;
    logic [2:0]  base_num_reg;

    logic        strobe_reg;
    logic        xfer_reg;
    logic [3:0]  reg_num_reg;
    logic [31:0] mem_addr_reg;
    logic        write_reg;
    logic [1:0]  kind_reg;
    logic        last_reg;
    logic        wb_valid_reg;
    logic [2:0]  wb_num_reg;
    logic [31:0] wb_value_reg;

    logic [15:0] lowest;
    logic [15:0] mask_rest;
    logic [3:0]  bit_idx;
    logic [3:0]  reg_num;
    logic        is_predec;
    logic        is_store;
    logic        has_wb;
    logic        empty;
    logic        is_last;
    logic [31:0] size;
    logic [31:0] addr_dec;
    logic [31:0] addr_inc;
    logic [31:0] emit_addr;
    logic [31:0] addr_next;
    logic [1:0]  kind;

    // Isolate the lowest remaining mask bit and encode its position.
    assign lowest    = mask_reg & (~mask_reg + 16'd1);
    assign mask_rest = mask_reg & ~lowest;

    always_comb
    begin
        bit_idx = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (lowest[i])
            begin
                bit_idx = bit_idx | 4'(i);
            end
        end
    end

    assign is_predec = (op_reg == mvm_pkg::OP_STORE_PREDEC);
    assign is_store  = (op_reg == mvm_pkg::OP_STORE_CTRL) ||
                       (op_reg == mvm_pkg::OP_STORE_PREDEC);
    assign has_wb    = (op_reg == mvm_pkg::OP_STORE_PREDEC) ||
                       (op_reg == mvm_pkg::OP_LOAD_POSTINC);
    assign empty     = (mask_reg == 16'd0);
    assign is_last   = empty || (mask_rest == 16'd0);

    // In predecrement mode the mask bit order is reversed.
    assign reg_num   = is_predec ? ~bit_idx : bit_idx;

    assign size      = long_reg ? mvm_pkg::SIZE_LONG : mvm_pkg::SIZE_WORD;
    assign addr_dec  = addr_reg - size;
    assign addr_inc  = addr_reg + size;
    assign emit_addr = is_predec ? addr_dec : addr_reg;
    assign addr_next = is_predec ? addr_dec : addr_inc;

    always_comb
    begin
        if (is_store || long_reg)
        begin
            kind = mvm_pkg::KIND_LONG;
        end
        else if (reg_num[3])
        begin
            kind = mvm_pkg::KIND_SIGN_WORD;
        end
        else
        begin
            kind = mvm_pkg::KIND_LOW_WORD;
        end
    end

    assign status.last = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mask_reg     <= reg_mask;
            addr_reg     <= start_address;
            op_reg       <= opcode;
            long_reg     <= long_size;
            base_num_reg <= base_reg;
        end
        else if (cmd.step)
        begin
            mask_reg <= mask_rest;
            if (!empty)
            begin
                addr_reg <= addr_next;
            end
        end

        if (cmd.step)
        begin
            xfer_reg     <= !empty;
            reg_num_reg  <= empty ? 4'd0 : reg_num;
            mem_addr_reg <= empty ? 32'd0 : emit_addr;
            write_reg    <= !empty && is_store;
            kind_reg     <= empty ? mvm_pkg::KIND_LONG : kind;
            last_reg     <= is_last;
            wb_valid_reg <= is_last && has_wb;
            wb_num_reg   <= (is_last && has_wb) ? base_num_reg : 3'd0;
            // An empty mask writes back the unchanged base address.
            if (is_last && has_wb)
            begin
                wb_value_reg <= empty ? addr_reg : addr_next;
            end
            else
            begin
                wb_value_reg <= 32'd0;
            end
        end
    end

    assign result_valid    = strobe_reg;
    assign transfer_valid  = xfer_reg;
    assign reg_index       = reg_num_reg;
    assign mem_address     = mem_addr_reg;
    assign is_write        = write_reg;
    assign load_kind       = kind_reg;
    assign last            = last_reg;
    assign writeback_valid = wb_valid_reg;
    assign writeback_reg   = wb_num_reg;
    assign writeback_value = wb_value_reg;

endmodule

// ===== design/movem_register_list_sequencer.sv =====
// ----------------------------------------------------------------------------
// movem_register_list_sequencer
// Expands one MOVEM instruction into its register transfers.
// ----------------------------------------------------------------------------
// Usage: present opcode, long_size, reg_mask, start_address and base_reg with
// start high; the transaction is taken at a clock edge where busy is low.
// The block then issues one result per set mask bit, lowest bit first, each
// on the result ports for one cycle with result_valid high. An empty mask
// gives one result with transfer_valid low. The final result has last high
// and, for predecrement and postincrement, the base register writeback.
// Order: the start edge loads the instruction and moves the controller to its
// run state; each step there registers one result onto the result ports.
// Throughput: an instruction occupies the block for one step per set mask bit
// (at least one step), since the mask scan retires one register per cycle;
// busy drops in the cycle the last result is shown.
// Reset clears the controller to idle and the result strobe to low.
// The receiver cannot stall: every result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module movem_register_list_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic        long_size,
    input  logic [15:0] reg_mask,
    input  logic [31:0] start_address,
    input  logic [2:0]  base_reg,
    output logic        result_valid,
    output logic        transfer_valid,
    output logic [3:0]  reg_index,
    output logic [31:0] mem_address,
    output logic        is_write,
    output logic [1:0]  load_kind,
    output logic        last,
    output logic        writeback_valid,
    output logic [2:0]  writeback_reg,
    output logic [31:0] writeback_value
);

    mvm_pkg::cmd_t    cmd;
    mvm_pkg::status_t status;

    mvm_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mvm_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .opcode          (opcode),
        .long_size       (long_size),
        .reg_mask        (reg_mask),
        .start_address   (start_address),
        .base_reg        (base_reg),
        .result_valid    (result_valid),
        .transfer_valid  (transfer_valid),
        .reg_index       (reg_index),
        .mem_address     (mem_address),
        .is_write        (is_write),
        .load_kind       (load_kind),
        .last            (last),
        .writeback_valid (writeback_valid),
        .writeback_reg   (writeback_reg),
        .writeback_value (writeback_value)
    );

`ifndef SYNTHESIS
    // A result is only produced by a step while the block was busy.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without an active transaction");

    // An accepted transaction keeps the block busy in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start");

    // Results of one instruction come back to back until the last one.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("gap before the last result of an instruction");

    // Only the last result may carry a writeback.
    a_wb_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && writeback_valid) |-> last)
        else $error("writeback on a result that is not last");
`endif

endmodule
